[design/uvsg_pkg.sv]
// Shared types, constants and helper functions for the UV sphere vertex generator.
package uvsg_pkg;

	localparam int RADIUS_W  = 16;
	localparam int HOFF_W    = 16;
	localparam int CNT_W     = 11;
	localparam int ROW_W     = 10;
	localparam int COL_W     = 10;
	localparam int CORNER_W  = 3;
	localparam int POS_W     = 20;
	localparam int NRM_W     = 16;
	localparam int TEX_W     = 17;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam int DEF_MAX_SUBDIVISIONS = 1024;
	localparam int DEF_CORDIC_STAGES    = 16;

	localparam int ANGLE_W     = 32;
	localparam int ANGLE_STEPS = 31;
	localparam int QUO_W       = ANGLE_W + 1;
	localparam int DIVX_W      = CNT_W + 1;
	localparam int TRIG_W      = 32;
	localparam int CW          = 34;
	localparam int ATAN_N      = 24;
	localparam int WIDE_W      = 40;

	localparam int TEX_STEP_U = 15;
	localparam int TEX_STEP_V = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIUS   = 2'd0,
		REG_HEIGHT   = 2'd1,
		REG_RADIAL   = 2'd2,
		REG_VERTICAL = 2'd3
	} cfg_reg_t;

	localparam logic [RADIUS_W-1:0] RADIUS_RST   = 16'd256;
	localparam logic [HOFF_W-1:0]   HEIGHT_RST   = 16'd0;
	localparam logic [CNT_W-1:0]    RADIAL_RST   = 11'd16;
	localparam logic [CNT_W-1:0]    VERTICAL_RST = 11'd16;
	localparam int                  RADIAL_MIN   = 3;
	localparam int                  VERTICAL_MIN = 2;

	localparam logic [CORNER_W-1:0] CORNER_POLE     = 3'd0;
	localparam logic [CORNER_W-1:0] CORNER_TOP_NEXT = 3'd1;
	localparam logic [CORNER_W-1:0] CORNER_BOT_NEXT = 3'd2;
	localparam logic [CORNER_W-1:0] CORNER_MAX_CAP  = 3'd2;
	localparam logic [CORNER_W-1:0] CORNER_MAX_BODY = 3'd5;

	localparam logic signed [CW-1:0]    CORDIC_GAIN = 34'sh026DD3B6A;
	localparam logic signed [NRM_W-1:0] NRM_ONE     = 16'sd16384;
	localparam logic [TEX_W-1:0]        TEX_ONE     = 17'd65536;

	localparam logic [31:0] ATAN_TABLE [ATAN_N] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
		32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	typedef struct packed {
		logic valid;
		logic err;
		logic pole;
		logic top;
	} side_t;

	typedef struct packed {
		side_t            side;
		logic [TEX_W-1:0] tex_u;
		logic [TEX_W-1:0] tex_v;
	} tside_t;

	function automatic logic body_da(input logic [CORNER_W-1:0] c);
		logic r;
		case (c) inside
			3'd1, 3'd4, 3'd5: r = 1'b1;
			default:          r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic body_db(input logic [CORNER_W-1:0] c);
		logic r;
		case (c) inside
			3'd1, 3'd2, 3'd5: r = 1'b1;
			default:          r = 1'b0;
		endcase
		return r;
	endfunction

	// remainder plus half the divisor reaches the divisor
	function automatic logic round_up(input logic [CNT_W-1:0] rem, input logic [CNT_W-1:0] dvs);
		return ({1'b0, rem} + {1'b0, dvs >> 1}) >= {1'b0, dvs};
	endfunction

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WIDE_W-1:0] v);
		if (v > 40'sd524287)
			return 20'sh7FFFF;
		else if (v < -40'sd524288)
			return 20'sh80000;
		else
			return v[POS_W-1:0];
	endfunction

	function automatic logic signed [NRM_W-1:0] sat_nrm(input logic signed [17:0] v);
		if (v > 18'sd16384)
			return NRM_ONE;
		else if (v < -18'sd16384)
			return -NRM_ONE;
		else
			return v[NRM_W-1:0];
	endfunction

endpackage

[design/uvsg_divider.sv]
// Pipelined restoring divider: binary angle and texture fraction from index over count.
module uvsg_divider import uvsg_pkg::*; #(
	parameter int TEX_STEP = TEX_STEP_V
) (
	input  logic                clk,
	input  logic [DIVX_W-1:0]   dividend,
	input  logic [CNT_W-1:0]    divisor,
	output logic [ANGLE_W-1:0]  angle,
	output logic [TEX_W-1:0]    frac
);

	logic [QUO_W-1:0]   q_s   [ANGLE_STEPS+1];
	logic [CNT_W-1:0]   rem_s [ANGLE_STEPS+1];
	logic [TEX_W-1:0]   tex_s [TEX_STEP+1:ANGLE_STEPS];
	logic [ANGLE_W-1:0] angle_q;
	logic [TEX_W-1:0]   frac_q;
	logic [DIVX_W-1:0]  d1;
	logic [DIVX_W-1:0]  d2;

	assign d1 = {1'b0, divisor};
	assign d2 = {divisor, 1'b0};

	// integer part, at most two for in-range requests
	always_ff @(posedge clk) begin
		if (dividend >= d2) begin
			q_s[0]   <= QUO_W'(2);
			rem_s[0] <= CNT_W'(dividend - d2);
		end else if (dividend >= d1) begin
			q_s[0]   <= QUO_W'(1);
			rem_s[0] <= CNT_W'(dividend - d1);
		end else begin
			q_s[0]   <= '0;
			rem_s[0] <= dividend[CNT_W-1:0];
		end
	end

	for (genvar k = 1; k <= ANGLE_STEPS; k++) begin : g_step
		logic [DIVX_W-1:0] sh;
		logic              ge;

		assign sh = {rem_s[k-1], 1'b0};
		assign ge = sh >= d1;

		always_ff @(posedge clk) begin
			q_s[k]   <= {q_s[k-1][QUO_W-2:0], ge};
			rem_s[k] <= ge ? CNT_W'(sh - d1) : sh[CNT_W-1:0];
		end

		if (k == TEX_STEP + 1) begin : g_tex
			always_ff @(posedge clk) begin
				tex_s[k] <= TEX_W'(q_s[k-1]) + TEX_W'(round_up(rem_s[k-1], divisor));
			end
		end else if (k > TEX_STEP + 1) begin : g_tex_dly
			always_ff @(posedge clk) begin
				tex_s[k] <= tex_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		angle_q <= ANGLE_W'(q_s[ANGLE_STEPS] + QUO_W'(round_up(rem_s[ANGLE_STEPS], divisor)));
		frac_q  <= tex_s[ANGLE_STEPS];
	end

	assign angle = angle_q;
	assign frac  = frac_q;

endmodule

[design/uvsg_cordic.sv]
// Pipelined rotation-mode CORDIC giving Q30 cosine and sine of a binary angle.
module uvsg_cordic import uvsg_pkg::*; #(
	parameter int STAGES = DEF_CORDIC_STAGES
) (
	input  logic                      clk,
	input  logic [ANGLE_W-1:0]        angle,
	output logic signed [TRIG_W-1:0]  cos_out,
	output logic signed [TRIG_W-1:0]  sin_out
);

	logic signed [CW-1:0] x_s [STAGES+1];
	logic signed [CW-1:0] y_s [STAGES+1];
	logic signed [CW-1:0] z_s [STAGES+1];
	logic                 flip_s [STAGES+1];
	logic signed [TRIG_W-1:0] cos_q;
	logic signed [TRIG_W-1:0] sin_q;
	logic                 flip;
	logic [ANGLE_W-1:0]   ang_f;

	// second and third quadrant: rotate by a half turn, negate at the end
	assign flip  = (angle[ANGLE_W-1:ANGLE_W-2] == 2'b01) || (angle[ANGLE_W-1:ANGLE_W-2] == 2'b10);
	assign ang_f = flip ? (angle ^ {1'b1, {(ANGLE_W-1){1'b0}}}) : angle;

	always_ff @(posedge clk) begin
		x_s[0]    <= CORDIC_GAIN;
		y_s[0]    <= '0;
		z_s[0]    <= CW'(signed'(ang_f));
		flip_s[0] <= flip;
	end

	for (genvar i = 1; i <= STAGES; i++) begin : g_rot
		logic signed [CW-1:0] at;

		assign at = signed'({2'b00, ATAN_TABLE[i-1]});

		always_ff @(posedge clk) begin
			if (!z_s[i-1][CW-1]) begin
				x_s[i] <= x_s[i-1] - (y_s[i-1] >>> (i-1));
				y_s[i] <= y_s[i-1] + (x_s[i-1] >>> (i-1));
				z_s[i] <= z_s[i-1] - at;
			end else begin
				x_s[i] <= x_s[i-1] + (y_s[i-1] >>> (i-1));
				y_s[i] <= y_s[i-1] - (x_s[i-1] >>> (i-1));
				z_s[i] <= z_s[i-1] + at;
			end
			flip_s[i] <= flip_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		cos_q <= flip_s[STAGES] ? TRIG_W'(-x_s[STAGES]) : TRIG_W'(x_s[STAGES]);
		sin_q <= flip_s[STAGES] ? TRIG_W'(-y_s[STAGES]) : TRIG_W'(y_s[STAGES]);
	end

	assign cos_out = cos_q;
	assign sin_out = sin_q;

endmodule

[design/uv_sphere_vertex_generator.sv]
// Top level of the UV sphere vertex generator: decode, dividers, CORDICs, scaling, output.
//
// channel   direction  handshake              payload
// command   in         start (busy is 0)      row_index, column_index, corner_index
// result    out        done, one cycle        pos_*, normal_*, tex_u, tex_v, index_error
// config    in         cfg_we                 cfg_index, cfg_data
//
// One request per cycle, one result per request, in order.
// From start to done a request passes the decode register, the
// one-bit-per-stage angle divider, the CORDIC, two multiply stages,
// one rounding stage and the output register.
// Reset clears the valid bits and loads the register reset values.
// busy stays low; results cannot be held off and the pipeline never stalls.
module uv_sphere_vertex_generator import uvsg_pkg::*; #(
	parameter int MAX_SUBDIVISIONS = DEF_MAX_SUBDIVISIONS,
	parameter int CORDIC_STAGES    = DEF_CORDIC_STAGES
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [ROW_W-1:0]         row_index,
	input  logic [COL_W-1:0]         column_index,
	input  logic [CORNER_W-1:0]      corner_index,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	output logic                     done,
	output logic signed [POS_W-1:0]  pos_x,
	output logic signed [POS_W-1:0]  pos_y,
	output logic signed [POS_W-1:0]  pos_z,
	output logic signed [NRM_W-1:0]  normal_x,
	output logic signed [NRM_W-1:0]  normal_y,
	output logic signed [NRM_W-1:0]  normal_z,
	output logic [TEX_W-1:0]         tex_u,
	output logic [TEX_W-1:0]         tex_v,
	output logic                     index_error
);

	localparam int CNT_MAX = (1 << CNT_W) - 1;
	localparam int R_HI    = (MAX_SUBDIVISIONS > CNT_MAX) ? CNT_MAX : MAX_SUBDIVISIONS;
	localparam int DIV_LAT = ANGLE_STEPS + 2;
	localparam int CL      = CORDIC_STAGES + 2;

	logic [RADIUS_W-1:0]      radius_q;
	logic signed [HOFF_W-1:0] height_q;
	logic [CNT_W-1:0]         radial_q;
	logic [CNT_W-1:0]         vertical_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q   <= RADIUS_RST;
			height_q   <= HEIGHT_RST;
			radial_q   <= RADIAL_RST;
			vertical_q <= VERTICAL_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RADIUS:   radius_q   <= cfg_data;
				REG_HEIGHT:   height_q   <= cfg_data;
				REG_RADIAL:   radial_q   <= cfg_data[CNT_W-1:0];
				REG_VERTICAL: vertical_q <= cfg_data[CNT_W-1:0];
			endcase
		end
	end

	logic [CNT_W-1:0] rc;
	logic [CNT_W-1:0] vc;
	logic [CNT_W-1:0] vc_m1;

	always_comb begin
		rc = radial_q;
		if (radial_q < CNT_W'(RADIAL_MIN))
			rc = CNT_W'(RADIAL_MIN);
		else if (radial_q > CNT_W'(R_HI))
			rc = CNT_W'(R_HI);
		vc = vertical_q;
		if (vertical_q < CNT_W'(VERTICAL_MIN))
			vc = CNT_W'(VERTICAL_MIN);
		else if (vertical_q > CNT_W'(R_HI))
			vc = CNT_W'(R_HI);
	end

	assign vc_m1 = vc - CNT_W'(1);

	// request decode
	logic              top;
	logic              bottom;
	logic              cap;
	logic              err;
	logic              pole;
	logic [CNT_W-1:0]  col_w;
	logic [CNT_W-1:0]  grid_a;
	logic [CNT_W-1:0]  grid_b;
	logic [DIVX_W-1:0] x_next;

	always_comb begin
		top    = row_index == '0;
		bottom = {1'b0, row_index} == vc_m1;
		cap    = top || bottom;
		err    = ({1'b0, row_index} >= vc) || ({1'b0, column_index} >= rc) ||
		         (corner_index > (cap ? CORNER_MAX_CAP : CORNER_MAX_BODY));
		pole   = cap && (corner_index == CORNER_POLE);
		col_w  = {1'b0, column_index};
		if (top) begin
			grid_a = col_w + CNT_W'(corner_index == CORNER_TOP_NEXT);
			grid_b = CNT_W'(1);
		end else if (bottom) begin
			grid_a = col_w + CNT_W'(corner_index == CORNER_BOT_NEXT);
			grid_b = vc_m1;
		end else begin
			grid_a = col_w + CNT_W'(body_da(corner_index));
			grid_b = {1'b0, row_index} + CNT_W'(body_db(corner_index));
		end
		// pole u sits half a segment in: divide 2i+1 instead of 2a
		x_next = pole ? {1'b0, column_index, 1'b1} : {grid_a, 1'b0};
	end

	side_t             side_s1;
	logic [DIVX_W-1:0] x_s1;
	logic [DIVX_W-1:0] y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			side_s1 <= '0;
		else
			side_s1 <= '{valid: start, err: err, pole: pole, top: top};
	end

	always_ff @(posedge clk) begin
		x_s1 <= x_next;
		y_s1 <= {1'b0, grid_b};
	end

	logic [ANGLE_W-1:0] phi;
	logic [ANGLE_W-1:0] theta;
	logic [TEX_W-1:0]   frac_u;
	logic [TEX_W-1:0]   frac_v;

	uvsg_divider #(.TEX_STEP(TEX_STEP_U)) u_div_u (
		.clk(clk), .dividend(x_s1), .divisor(rc), .angle(phi), .frac(frac_u)
	);

	uvsg_divider #(.TEX_STEP(TEX_STEP_V)) u_div_v (
		.clk(clk), .dividend(y_s1), .divisor(vc), .angle(theta), .frac(frac_v)
	);

	side_t dly_div_s [DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++)
				dly_div_s[i] <= '0;
		end else begin
			dly_div_s[0] <= side_s1;
			for (int i = 1; i < DIV_LAT; i++)
				dly_div_s[i] <= dly_div_s[i-1];
		end
	end

	logic signed [TRIG_W-1:0] cos_phi;
	logic signed [TRIG_W-1:0] sin_phi;
	logic signed [TRIG_W-1:0] cos_th;
	logic signed [TRIG_W-1:0] sin_th;

	uvsg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_phi (
		.clk(clk), .angle(phi), .cos_out(cos_phi), .sin_out(sin_phi)
	);

	uvsg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_th (
		.clk(clk), .angle(theta), .cos_out(cos_th), .sin_out(sin_th)
	);

	tside_t dly_trig_s [CL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CL; i++)
				dly_trig_s[i] <= '0;
		end else begin
			dly_trig_s[0] <= '{side: dly_div_s[DIV_LAT-1], tex_u: frac_u, tex_v: frac_v};
			for (int i = 1; i < CL; i++)
				dly_trig_s[i] <= dly_trig_s[i-1];
		end
	end

	logic signed [RADIUS_W:0] r_sgn;

	assign r_sgn = signed'({1'b0, radius_q});

	// products of the unit sphere point and radius times cos(theta)
	tside_t                        ts_s2;
	logic signed [2*TRIG_W-1:0]    p_xs_s2;
	logic signed [2*TRIG_W-1:0]    p_zs_s2;
	logic signed [RADIUS_W+TRIG_W:0] p_yr_s2;
	logic signed [TRIG_W-1:0]      ct_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ts_s2 <= '0;
		else
			ts_s2 <= dly_trig_s[CL-1];
	end

	always_ff @(posedge clk) begin
		p_xs_s2 <= cos_phi * sin_th;
		p_zs_s2 <= sin_phi * sin_th;
		p_yr_s2 <= r_sgn * cos_th;
		ct_s2   <= cos_th;
	end

	logic signed [2*TRIG_W-1:0]      t_x;
	logic signed [2*TRIG_W-1:0]      t_z;
	logic signed [RADIUS_W+TRIG_W:0] t_y;
	logic signed [TRIG_W:0]          t_ny;

	always_comb begin
		t_x  = (p_xs_s2 + 64'sh2000_0000) >>> 30;
		t_z  = (p_zs_s2 + 64'sh2000_0000) >>> 30;
		t_y  = (p_yr_s2 + 49'sh2000_0000) >>> 30;
		t_ny = (33'(ct_s2) + 33'sd32768) >>> 16;
	end

	tside_t                   ts_s3;
	logic signed [TRIG_W-1:0] mx_s3;
	logic signed [TRIG_W-1:0] mz_s3;
	logic signed [WIDE_W-1:0] y_s3;
	logic signed [NRM_W-1:0]  ny_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ts_s3 <= '0;
		else
			ts_s3 <= ts_s2;
	end

	always_ff @(posedge clk) begin
		mx_s3 <= t_x[TRIG_W-1:0];
		mz_s3 <= t_z[TRIG_W-1:0];
		y_s3  <= signed'(t_y[WIDE_W-1:0]) + WIDE_W'(height_q);
		ny_s3 <= sat_nrm(t_ny[17:0]);
	end

	logic signed [TRIG_W:0] t_nx;
	logic signed [TRIG_W:0] t_nz;

	always_comb begin
		t_nx = (33'(mx_s3) + 33'sd32768) >>> 16;
		t_nz = (33'(mz_s3) + 33'sd32768) >>> 16;
	end

	tside_t                          ts_s4;
	logic signed [RADIUS_W+TRIG_W:0] p_x_s4;
	logic signed [RADIUS_W+TRIG_W:0] p_z_s4;
	logic signed [WIDE_W-1:0]        y_s4;
	logic signed [NRM_W-1:0]         nx_s4;
	logic signed [NRM_W-1:0]         ny_s4;
	logic signed [NRM_W-1:0]         nz_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ts_s4 <= '0;
		else
			ts_s4 <= ts_s3;
	end

	always_ff @(posedge clk) begin
		p_x_s4 <= r_sgn * mx_s3;
		p_z_s4 <= r_sgn * mz_s3;
		y_s4   <= y_s3;
		nx_s4  <= sat_nrm(t_nx[17:0]);
		ny_s4  <= ny_s3;
		nz_s4  <= sat_nrm(t_nz[17:0]);
	end

	logic signed [RADIUS_W+TRIG_W:0] t_px;
	logic signed [RADIUS_W+TRIG_W:0] t_pz;
	logic signed [WIDE_W-1:0]        r_wide;
	logic signed [WIDE_W-1:0]        pole_y;

	always_comb begin
		t_px   = (p_x_s4 + 49'sh2000_0000) >>> 30;
		t_pz   = (p_z_s4 + 49'sh2000_0000) >>> 30;
		r_wide = signed'(WIDE_W'(radius_q));
		pole_y = (ts_s4.side.top ? r_wide : -r_wide) + WIDE_W'(height_q);
	end

	logic                     done_q;
	logic signed [POS_W-1:0]  pos_x_q;
	logic signed [POS_W-1:0]  pos_y_q;
	logic signed [POS_W-1:0]  pos_z_q;
	logic signed [NRM_W-1:0]  nx_q;
	logic signed [NRM_W-1:0]  ny_q;
	logic signed [NRM_W-1:0]  nz_q;
	logic [TEX_W-1:0]         tex_u_q;
	logic [TEX_W-1:0]         tex_v_q;
	logic                     err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= ts_s4.side.valid;
	end

	always_ff @(posedge clk) begin
		if (ts_s4.side.err) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
			nx_q    <= '0;
			ny_q    <= '0;
			nz_q    <= '0;
			tex_u_q <= '0;
			tex_v_q <= '0;
			err_q   <= 1'b1;
		end else if (ts_s4.side.pole) begin
			pos_x_q <= '0;
			pos_y_q <= sat_pos(pole_y);
			pos_z_q <= '0;
			nx_q    <= '0;
			ny_q    <= ts_s4.side.top ? NRM_ONE : -NRM_ONE;
			nz_q    <= '0;
			tex_u_q <= ts_s4.tex_u;
			tex_v_q <= ts_s4.side.top ? '0 : TEX_ONE;
			err_q   <= 1'b0;
		end else begin
			pos_x_q <= sat_pos(signed'(t_px[WIDE_W-1:0]));
			pos_y_q <= sat_pos(y_s4);
			pos_z_q <= sat_pos(signed'(t_pz[WIDE_W-1:0]));
			nx_q    <= nx_s4;
			ny_q    <= ny_s4;
			nz_q    <= nz_s4;
			tex_u_q <= ts_s4.tex_u;
			tex_v_q <= ts_s4.tex_v;
			err_q   <= 1'b0;
		end
	end

	assign busy        = 1'b0;
	assign done        = done_q;
	assign pos_x       = pos_x_q;
	assign pos_y       = pos_y_q;
	assign pos_z       = pos_z_q;
	assign normal_x    = nx_q;
	assign normal_y    = ny_q;
	assign normal_z    = nz_q;
	assign tex_u       = tex_u_q;
	assign tex_v       = tex_v_q;
	assign index_error = err_q;

`ifndef SYNTH
	localparam int LATENCY = DIV_LAT + CL + 5;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("transfer accepted but no result after pipeline latency");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without a matching accepted transfer");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && index_error |-> pos_x == '0 && pos_y == '0 && pos_z == '0 &&
			normal_x == '0 && normal_y == '0 && normal_z == '0 &&
			tex_u == '0 && tex_v == '0)
		else $error("index error result carries nonzero fields");
`endif

endmodule

[tb/uv_sphere_vertex_generator_tb.sv]
// Self-checking testbench for the UV sphere vertex generator: predicted vertices vs. DUT results.
module uv_sphere_vertex_generator_tb;
	import uvsg_pkg::*;

	typedef enum logic {K_CORNER, K_WRITE} job_kind_t;

	typedef struct {
		job_kind_t            kind;
		logic [ROW_W-1:0]     row;
		logic [COL_W-1:0]     col;
		logic [CORNER_W-1:0]  corner;
		cfg_reg_t             idx;
		logic [CFG_W-1:0]     data;
		logic                 nogap;
	} job_t;

	typedef struct {
		logic signed [POS_W-1:0] px, py, pz;
		logic signed [NRM_W-1:0] nx, ny, nz;
		logic [TEX_W-1:0]        u, v;
		logic                    err;
	} vertex_t;

	localparam int WATCHDOG_LIMIT = 4000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [ROW_W-1:0]    row_index = '0;
	logic [COL_W-1:0]    column_index = '0;
	logic [CORNER_W-1:0] corner_index = '0;
	logic                cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]    cfg_data = '0;
	logic                done;
	logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
	logic signed [NRM_W-1:0] normal_x, normal_y, normal_z;
	logic [TEX_W-1:0]    tex_u, tex_v;
	logic                index_error;

	job_t    pending_jobs[$];
	vertex_t expected_vertices[$];

	// predictor copy of the registers
	logic [RADIUS_W-1:0]      radius_q = RADIUS_RST;
	logic signed [HOFF_W-1:0] height_q = HEIGHT_RST;
	logic [CNT_W-1:0]         radial_q = RADIAL_RST;
	logic [CNT_W-1:0]         vertical_q = VERTICAL_RST;

	int mismatches = 0;
	int corners_sent = 0;
	int vertices_seen = 0;
	int writes_done = 0;
	int errors_seen = 0;
	int gap = 0;
	int idle_cycles = 0;

	uv_sphere_vertex_generator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.row_index(row_index), .column_index(column_index), .corner_index(corner_index),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.tex_u(tex_u), .tex_v(tex_v), .index_error(index_error)
	);

	always #4 clk = ~clk;

	function automatic int eff_radial(input logic [CNT_W-1:0] n);
		if (n < RADIAL_MIN) return RADIAL_MIN;
		if (n > DEF_MAX_SUBDIVISIONS) return DEF_MAX_SUBDIVISIONS;
		return n;
	endfunction

	function automatic int eff_vertical(input logic [CNT_W-1:0] n);
		if (n < VERTICAL_MIN) return VERTICAL_MIN;
		if (n > DEF_MAX_SUBDIVISIONS) return DEF_MAX_SUBDIVISIONS;
		return n;
	endfunction

	function automatic longint round_shift(input longint v, input int sh);
		return (v + (longint'(1) << (sh - 1))) >>> sh;
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	task automatic rotate_angle(input logic [31:0] ang, output longint c, output longint s);
		logic   flip;
		longint x, y, z, nx;
		flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
		if (flip) ang = ang + 32'h80000000;
		x = longint'(CORDIC_GAIN);
		y = 0;
		z = longint'($signed(ang));
		for (int i = 0; i < DEF_CORDIC_STAGES; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - longint'(ATAN_TABLE[i]);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + longint'(ATAN_TABLE[i]);
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	task automatic sphere_point(input longint a, input longint b, input longint nr,
			input longint nv, input longint r, input longint h, inout vertex_t vt);
		logic [31:0] phi, theta;
		longint cp, sp, ct, st, mx, mz;
		phi = 32'(((a << 32) + nr / 2) / nr);
		theta = 32'((b * 64'h80000000 + nv / 2) / nv);
		rotate_angle(phi, cp, sp);
		rotate_angle(theta, ct, st);
		mx = round_shift(cp * st, 30);
		mz = round_shift(sp * st, 30);
		vt.px = POS_W'(clip(round_shift(r * mx, 30), -524288, 524287));
		vt.py = POS_W'(clip(round_shift(r * ct, 30) + h, -524288, 524287));
		vt.pz = POS_W'(clip(round_shift(r * mz, 30), -524288, 524287));
		vt.nx = NRM_W'(clip(round_shift(mx, 16), -16384, 16384));
		vt.ny = NRM_W'(clip(round_shift(ct, 16), -16384, 16384));
		vt.nz = NRM_W'(clip(round_shift(mz, 16), -16384, 16384));
		vt.u = TEX_W'((a * 65536 + nr / 2) / nr);
		vt.v = TEX_W'((b * 65536 + nv / 2) / nv);
	endtask

	task automatic predict_vertex(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
			input logic [CORNER_W-1:0] corner, output vertex_t vt);
		longint nr, nv, r, h, da, db;
		logic   top, bottom;
		nr = eff_radial(radial_q);
		nv = eff_vertical(vertical_q);
		r = radius_q;
		h = height_q;
		top = (row == 0);
		bottom = (row == nv - 1);
		vt = '{default: '0};
		if (row >= nv || col >= nr || corner > ((top || bottom) ? CORNER_MAX_CAP
				: CORNER_MAX_BODY)) begin
			vt.err = 1'b1;
		end else if ((top || bottom) && corner == CORNER_POLE) begin
			vt.py = POS_W'(clip((top ? r : -r) + h, -524288, 524287));
			vt.ny = top ? NRM_ONE : -NRM_ONE;
			vt.u = TEX_W'(((2 * longint'(col) + 1) * 65536 + nr) / (2 * nr));
			vt.v = top ? '0 : TEX_ONE;
		end else if (top) begin
			sphere_point(corner == CORNER_TOP_NEXT ? col + 1 : col, 1, nr, nv, r, h, vt);
		end else if (bottom) begin
			sphere_point(corner == CORNER_BOT_NEXT ? col + 1 : col, nv - 1, nr, nv, r, h, vt);
		end else begin
			da = (corner == 1 || corner == 4 || corner == 5);
			db = (corner == 1 || corner == 2 || corner == 5);
			sphere_point(col + da, row + db, nr, nv, r, h, vt);
		end
	endtask

	task automatic report(input string field, input longint got, input longint want);
		$display("result %0d: %s is %0d, expected %0d", vertices_seen, field, got, want);
		mismatches++;
	endtask

	task automatic push_corner(input int row, input int col, input int corner,
			input logic nogap = 1'b0);
		job_t j;
		j = '{kind: K_CORNER, row: ROW_W'(row), col: COL_W'(col),
			corner: CORNER_W'(corner), idx: REG_RADIUS, data: '0, nogap: nogap};
		pending_jobs.insert(pending_jobs.size(), j);
	endtask

	task automatic push_write(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
		job_t j;
		j = '{kind: K_WRITE, row: '0, col: '0, corner: '0, idx: idx, data: data, nogap: 1'b0};
		pending_jobs.insert(pending_jobs.size(), j);
	endtask

	task automatic push_setting(input int r, input int h, input int nr, input int nv);
		push_write(REG_RADIUS, CFG_W'(r));
		push_write(REG_HEIGHT, CFG_W'(h));
		push_write(REG_RADIAL, CFG_W'(nr));
		push_write(REG_VERTICAL, CFG_W'(nv));
	endtask

	// mostly legal corners of the current grid, some raw noise
	task automatic push_random_corners(input int n, input int nr, input int nv);
		int row, col, corner;
		logic burst;
		burst = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				row = $urandom_range(0, 1023);
				col = $urandom_range(0, 1023);
				corner = $urandom_range(0, 7);
			end else begin
				row = $urandom_range(0, nv - 1);
				col = $urandom_range(0, nr - 1);
				corner = $urandom_range(0, (row == 0 || row == nv - 1) ? 2 : 5);
			end
			push_corner(row, col, corner, burst);
		end
	endtask

	// driver
	always @(negedge clk) begin
		logic     nstart, nwe;
		job_t     j;
		if (arst_n) begin
			nstart = 1'b0;
			nwe = 1'b0;
			if (start && !busy) begin
				j = pending_jobs.pop_front();
				corners_sent++;
				if (j.nogap) gap = 0;
				else case ($urandom_range(0, 99)) inside
					[0:59]:  gap = 0;
					[60:89]: gap = $urandom_range(1, 3);
					[90:97]: gap = $urandom_range(4, 20);
					default: gap = $urandom_range(50, 200);
				endcase
			end
			if (gap > 0) begin
				gap--;
			end else if (pending_jobs.size() > 0) begin
				j = pending_jobs[0];
				if (j.kind == K_CORNER) begin
					nstart = 1'b1;
					row_index <= j.row;
					column_index <= j.col;
					corner_index <= j.corner;
				end else if (expected_vertices.size() == 0) begin
					nwe = 1'b1;
					cfg_index <= j.idx;
					cfg_data <= j.data;
					void'(pending_jobs.pop_front());
				end
			end
			start <= nstart;
			cfg_we <= nwe;
		end
	end

	// monitor and scoreboard
	always @(posedge clk) begin
		vertex_t want;
		if (arst_n) begin
			idle_cycles++;
			if (cfg_we) begin
				writes_done++;
				case (cfg_reg_t'(cfg_index))
					REG_RADIUS:   radius_q <= cfg_data;
					REG_HEIGHT:   height_q <= cfg_data;
					REG_RADIAL:   radial_q <= cfg_data[CNT_W-1:0];
					REG_VERTICAL: vertical_q <= cfg_data[CNT_W-1:0];
				endcase
			end
			if (start && !busy) begin
				idle_cycles = 0;
				predict_vertex(row_index, column_index, corner_index, want);
				expected_vertices.insert(expected_vertices.size(), want);
			end
			if (done) begin
				idle_cycles = 0;
				vertices_seen++;
				if (index_error) errors_seen++;
				if (expected_vertices.size() == 0) begin
					$display("result %0d arrived with nothing outstanding", vertices_seen);
					mismatches++;
				end else begin
					want = expected_vertices.pop_front();
					if (pos_x !== want.px) report("pos_x", pos_x, want.px);
					if (pos_y !== want.py) report("pos_y", pos_y, want.py);
					if (pos_z !== want.pz) report("pos_z", pos_z, want.pz);
					if (normal_x !== want.nx) report("normal_x", normal_x, want.nx);
					if (normal_y !== want.ny) report("normal_y", normal_y, want.ny);
					if (normal_z !== want.nz) report("normal_z", normal_z, want.nz);
					if (tex_u !== want.u) report("tex_u", tex_u, want.u);
					if (tex_v !== want.v) report("tex_v", tex_v, want.v);
					if (index_error !== want.err) report("index_error", index_error, want.err);
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("uv_sphere_vertex_generator: mismatch");
				$finish;
			end
		end
	end

	initial begin
		int r, h, nr, nv;
		// reset values: 16 x 16 grid, radius 256
		for (int c = 0; c <= 2; c++) push_corner(0, 3, c);
		for (int c = 0; c <= 2; c++) push_corner(15, 15, c);
		for (int c = 0; c <= 5; c++) push_corner(7, 15, c);
		push_corner(0, 0, 3);
		push_corner(15, 4, 7);
		push_corner(1, 0, 6);
		push_corner(16, 0, 0);
		push_corner(2, 16, 1);
		push_corner(1023, 1023, 7);
		push_corner(14, 0, 5);
		push_corner(0, 0, 0);
		push_corner(15, 0, 0);
		push_random_corners(140, 16, 16);

		push_setting(65535, 16'h7FFF, 1024, 1024);
		push_corner(0, 1023, 1);
		push_corner(1023, 1023, 2);
		push_corner(512, 511, 5);
		push_random_corners(140, 1024, 1024);

		push_setting(1, 16'h8000, 3, 2);
		push_corner(0, 2, 1);
		push_corner(1, 2, 2);
		push_corner(1, 0, 0);
		push_random_corners(140, 3, 2);

		// out-of-range counts clamp; zero radius
		push_setting(0, 16'h0100, 0, 0);
		push_random_corners(80, 3, 2);
		push_setting(0, 16'hFF00, 2047, 2047);
		push_random_corners(80, 1024, 1024);

		repeat (5) begin
			r = $urandom_range(0, 65535);
			h = $urandom_range(0, 65535);
			nr = $urandom_range(3, 64);
			nv = $urandom_range(2, 64);
			if ($urandom_range(0, 3) == 0) nr = $urandom_range(3, 1024);
			push_setting(r, h, nr, nv);
			push_random_corners(120, nr, nv);
		end

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		wait (pending_jobs.size() == 0 && expected_vertices.size() == 0);
		repeat (80) @(posedge clk);
		$display("%0d corner requests, %0d vertices checked (%0d index errors), %0d register writes",
			corners_sent, vertices_seen, errors_seen, writes_done);
		if (mismatches == 0 && expected_vertices.size() == 0)
			$display("uv_sphere_vertex_generator: match");
		else
			$display("uv_sphere_vertex_generator: mismatch");
		$finish;
	end

endmodule

[uv_sphere_vertex_generator.f]
design/uvsg_pkg.sv
design/uvsg_divider.sv
design/uvsg_cordic.sv
design/uv_sphere_vertex_generator.sv
tb/uv_sphere_vertex_generator_tb.sv
